// ----- src/servo_keyframe_interpolator_macros.svh -----
`ifndef SERVO_KEYFRAME_INTERPOLATOR_MACROS_SVH
`define SERVO_KEYFRAME_INTERPOLATOR_MACROS_SVH

// same-cycle implication, checked on clk, quiet in reset
`define SKI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SKI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/skint_pkg.sv -----
package skint_pkg;

	typedef struct packed {
		logic [2:0] action;
		logic       table_select;
		logic [7:0] start_angle;
		logic [7:0] stop_angle;
		logic [9:0] unit_count;
		logic [7:0] ticks_per_unit;
	} item_t;

	typedef struct packed {
		logic [7:0] angle_out;
		logic       op_ok;
		logic       finished;
		logic [4:0] segment_now;
	} result_t;

	// one table entry, 34 bits
	typedef struct packed {
		logic [7:0] start;
		logic [7:0] stop;
		logic [9:0] units;
		logic [7:0] mult;
	} entry_t;

	localparam logic [2:0] ACT_TICK    = 3'd0;
	localparam logic [2:0] ACT_PUSH    = 3'd1;
	localparam logic [2:0] ACT_POP     = 3'd2;
	localparam logic [2:0] ACT_RESTART = 3'd3;
	localparam logic [2:0] ACT_LOOP    = 3'd4;

	localparam logic [9:0] ANGLE_MAX = 10'd180;

	typedef struct packed {
		logic capture;
		logic exec;
		logic rd;
		logic step;
		logic div_step;
		logic add;
		logic reload;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic tick;
		logic hold;
		logic seg_end;
		logic play_stop;
		logic div_last;
	} stat_t;

endpackage

// ----- src/servo_keyframe_interpolator.sv -----
// Tick with interpolation: decode, step, restoring division, accumulator add, then the
//   result is posted; the restoring divider produces one quotient bit per cycle.
// Tick at a segment boundary: decode, step, next-entry read, reload; tick ending initial table:
//   decode, step; hold, push, pop, restart, loop switch: decode only.
// A new word is accepted the cycle after the previous result is posted to the output register.
// arst_n clears counts, playback counters, mode and accumulator; table contents are not cleared.
module servo_keyframe_interpolator #(
	parameter int TABLE_DEPTH   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  skint_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output skint_pkg::result_t result
);

	skint_pkg::cmd_t  cmd;
	skint_pkg::stat_t stat;

	skint_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	skint_datapath #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

// ----- src/skint_datapath.sv -----
`include "servo_keyframe_interpolator_macros.svh"

module skint_datapath #(
	parameter int TABLE_DEPTH   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  skint_pkg::item_t   item,
	input  skint_pkg::cmd_t    cmd,
	output skint_pkg::stat_t   stat,
	output skint_pkg::result_t result
);

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int ACCW = FRACTION_BITS + 10;
	localparam int NW   = FRACTION_BITS + 8;
	localparam int DW   = 18;
	localparam int DCW  = $clog2(NW);

	skint_pkg::item_t   item_q;
	skint_pkg::entry_t  ini_mem [TABLE_DEPTH];
	skint_pkg::entry_t  lp_mem  [TABLE_DEPTH];
	skint_pkg::entry_t  ini_rd_q, lp_rd_q;
	skint_pkg::entry_t  ent, wr_ent;
	skint_pkg::result_t result_q;

	logic [CW-1:0]   ini_cnt_q, lp_cnt_q, idx_q;
	logic            loop_q, ok_q;
	logic [7:0]      sub_q;
	logic [9:0]      units_q;
	logic [ACCW-1:0] acc_q;
	logic [DW-1:0]   prod_q, rem_q;
	logic            neg_q;
	logic [NW-1:0]   quo_q;
	logic [DCW-1:0]  dcnt_q;

	logic [CW-1:0]   act_cnt, sel_cnt, idx_inc;
	logic [7:0]      sub_inc, sub_nx, diff;
	logic [9:0]      units_nx, ip;
	logic            unit_roll, at_end, first, neg, push_ok;
	logic [NW-1:0]   num;
	logic [DW-1:0]   prod;
	logic [DW:0]     rem_w, rem_sub;
	logic            fits;
	logic [ACCW-1:0] mag, inc, start_fx;
	logic [7:0]      angle;
	logic [CW+4:0]   idx_ext;

	assign wr_ent = '{start: item_q.start_angle, stop: item_q.stop_angle,
		units: item_q.unit_count, mult: item_q.ticks_per_unit};

	assign ent     = loop_q ? lp_rd_q : ini_rd_q;
	assign act_cnt = loop_q ? lp_cnt_q : ini_cnt_q;
	assign sel_cnt = item_q.table_select ? ini_cnt_q : lp_cnt_q;
	assign push_ok = sel_cnt < CW'(TABLE_DEPTH);

	assign sub_inc   = sub_q + 8'd1;
	assign unit_roll = sub_inc >= ent.mult;
	assign sub_nx    = unit_roll ? 8'd0 : sub_inc;
	assign units_nx  = unit_roll ? units_q + 10'd1 : units_q;
	assign idx_inc   = idx_q + CW'(1);
	assign at_end    = idx_inc >= act_cnt;
	assign first     = (idx_q == '0) && (sub_q == 8'd0) && (units_q == 10'd0);

	assign neg  = ent.stop < ent.start;
	assign diff = neg ? ent.start - ent.stop : ent.stop - ent.start;
	assign num  = {diff, {FRACTION_BITS{1'b0}}};
	assign prod = DW'(ent.mult) * DW'(ent.units);

	// restoring divider, one quotient bit per cycle
	assign rem_w   = {rem_q, quo_q[NW-1]};
	assign fits    = rem_w >= {1'b0, prod_q};
	assign rem_sub = rem_w - {1'b0, prod_q};

	assign mag      = {2'b00, quo_q};
	assign inc      = (prod_q == '0) ? '0 : (neg_q ? ACCW'(0) - mag : mag);
	assign start_fx = {2'b00, ent.start, {FRACTION_BITS{1'b0}}};

	assign stat.tick      = item_q.action == skint_pkg::ACT_TICK;
	assign stat.hold      = (act_cnt == '0) || (idx_q >= act_cnt);
	assign stat.seg_end   = units_nx >= ent.units;
	assign stat.play_stop = at_end && !loop_q;
	assign stat.div_last  = dcnt_q == DCW'(NW - 1);

	assign ip      = acc_q[ACCW-1:FRACTION_BITS];
	assign angle   = acc_q[ACCW-1] ? 8'd0 :
		(ip > skint_pkg::ANGLE_MAX ? skint_pkg::ANGLE_MAX[7:0] : ip[7:0]);
	assign idx_ext = {5'b00000, idx_q};

	assign result = result_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.exec && item_q.action == skint_pkg::ACT_PUSH && push_ok) begin
			if (item_q.table_select) begin
				ini_mem[ini_cnt_q[AW-1:0]] <= wr_ent;
			end else begin
				lp_mem[lp_cnt_q[AW-1:0]] <= wr_ent;
			end
		end
		if (cmd.rd) begin
			ini_rd_q <= ini_mem[idx_q[AW-1:0]];
			lp_rd_q  <= lp_mem[idx_q[AW-1:0]];
		end
		if (cmd.step) begin
			prod_q <= prod;
			neg_q  <= neg;
			rem_q  <= '0;
			quo_q  <= num;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= fits ? rem_sub[DW-1:0] : rem_w[DW-1:0];
			quo_q  <= {quo_q[NW-2:0], fits};
			dcnt_q <= dcnt_q + DCW'(1);
		end
		if (cmd.out_load) begin
			result_q <= '{angle_out: angle, op_ok: ok_q,
				finished: !loop_q && ini_cnt_q != '0 && idx_q >= ini_cnt_q,
				segment_now: idx_ext[4:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ini_cnt_q <= '0;
			lp_cnt_q  <= '0;
			loop_q    <= 1'b0;
			ok_q      <= 1'b0;
			idx_q     <= '0;
			sub_q     <= 8'd0;
			units_q   <= 10'd0;
			acc_q     <= '0;
		end else begin
			if (cmd.exec) begin
				ok_q <= (item_q.action == skint_pkg::ACT_PUSH && push_ok) ||
					(item_q.action == skint_pkg::ACT_POP && sel_cnt != '0);
				case (item_q.action)
					skint_pkg::ACT_PUSH: begin
						if (push_ok) begin
							if (item_q.table_select) begin
								ini_cnt_q <= ini_cnt_q + CW'(1);
							end else begin
								lp_cnt_q <= lp_cnt_q + CW'(1);
							end
						end
					end
					skint_pkg::ACT_POP: begin
						if (sel_cnt != '0) begin
							if (item_q.table_select) begin
								ini_cnt_q <= ini_cnt_q - CW'(1);
							end else begin
								lp_cnt_q <= lp_cnt_q - CW'(1);
							end
						end
					end
					skint_pkg::ACT_RESTART: begin
						idx_q   <= '0;
						sub_q   <= 8'd0;
						units_q <= 10'd0;
					end
					skint_pkg::ACT_LOOP: begin
						loop_q  <= 1'b1;
						idx_q   <= '0;
						sub_q   <= 8'd0;
						units_q <= 10'd0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.step) begin
				if (first) begin
					acc_q <= start_fx;
				end
				sub_q <= sub_nx;
				if (stat.seg_end) begin
					units_q <= 10'd0;
					idx_q   <= (at_end && loop_q) ? '0 : idx_inc;
				end else begin
					units_q <= units_nx;
				end
			end
			if (cmd.add) begin
				acc_q <= acc_q + inc;
			end
			if (cmd.reload) begin
				acc_q <= start_fx;
			end
		end
	end

	`SKI_ASSERT_SAME(a_ini_cnt_range, 1'b1, ini_cnt_q <= CW'(TABLE_DEPTH), "initial count overflow")
	`SKI_ASSERT_SAME(a_lp_cnt_range, 1'b1, lp_cnt_q <= CW'(TABLE_DEPTH), "loop count overflow")
	`SKI_ASSERT_NEXT(a_next_seg_valid, cmd.step && stat.seg_end && !stat.play_stop, idx_q < act_cnt, "next segment out of table")

endmodule

// ----- src/skint_ctrl.sv -----
`include "servo_keyframe_interpolator_macros.svh"

module skint_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	output logic             result_valid,
	input  logic             result_stall,
	input  skint_pkg::stat_t stat,
	output skint_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_DEC, S_CUR, S_DIV, S_ADD, S_NRD, S_NLD, S_FIN
	} state_t;

	state_t state_q;
	logic   res_valid_q;
	logic   slot_free;

	assign slot_free    = !res_valid_q || !result_stall;
	assign item_stall   = state_q != S_IDLE;
	assign result_valid = res_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && item_valid;
		cmd.exec     = state_q == S_DEC;
		cmd.rd       = (state_q == S_DEC) || (state_q == S_NRD);
		cmd.step     = state_q == S_CUR;
		cmd.div_step = state_q == S_DIV;
		cmd.add      = state_q == S_ADD;
		cmd.reload   = state_q == S_NLD;
		cmd.out_load = (state_q == S_FIN) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= (stat.tick && !stat.hold) ? S_CUR : S_FIN;
				end
				S_CUR: begin
					if (stat.seg_end) begin
						state_q <= stat.play_stop ? S_FIN : S_NRD;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (stat.div_last) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: state_q <= S_FIN;
				S_NRD: state_q <= S_NLD;
				S_NLD: state_q <= S_FIN;
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SKI_ASSERT_NEXT(a_accept_decodes, state_q == S_IDLE && item_valid, state_q == S_DEC, "accepted word not decoded")
	`SKI_ASSERT_NEXT(a_div_ends, state_q == S_DIV && stat.div_last, state_q == S_ADD, "divider did not hand over")
	`SKI_ASSERT_NEXT(a_fin_posts, state_q == S_FIN && slot_free, res_valid_q && state_q == S_IDLE, "result not posted")

endmodule
